// File: hw/rtl/smcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smcc_pkg
// Types, codes and constants shared by the shunt monitor calibrate and
// convert unit and its channel interfaces.
// ----------------------------------------------------------------------------
package smcc_pkg;

    // Request codes.
    localparam logic [2:0] REQ_CAL   = 3'd0;
    localparam logic [2:0] REQ_SHUNT = 3'd1;
    localparam logic [2:0] REQ_BUS   = 3'd2;
    localparam logic [2:0] REQ_CUR   = 3'd3;
    localparam logic [2:0] REQ_PWR   = 3'd4;

    // Status codes.
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_CUR_LOW     = 3'd1;
    localparam logic [2:0] ST_SHUNT_LOW   = 3'd2;
    localparam logic [2:0] ST_VSHUNT_HIGH = 3'd3;
    localparam logic [2:0] ST_CAL_OVF     = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_IMAX  = 2'd0;
    localparam logic [1:0] CFG_SHUNT = 2'd1;
    localparam logic [1:0] CFG_GAIN  = 2'd2;

    // Arithmetic constants.
    localparam logic [45:0] CAL_NUM        = 46'd40960000000000;
    localparam logic [19:0] NANO_PER_MILLI = 20'd1000000;
    localparam logic [23:0] SHUNT_MIN      = 24'd1000;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] raw_word;
    } t_req;

    typedef struct packed {
        logic signed [31:0] scaled_value;
        logic [2:0]         status;
        logic [14:0]        calibration_word;
    } t_rsp;

    // Largest allowed imax * shunt product in nV for each shunt range.
    function automatic logic [28:0] fs_limit(input logic [1:0] gain);
        logic [28:0] v;
        unique case (gain)
            2'd0:    v = 29'd39980000;
            2'd1:    v = 29'd79980000;
            2'd2:    v = 29'd159980000;
            default: v = 29'd319980000;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/smcc_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smcc_req_if
// Request channel: valid/ready handshake carrying one request per beat.
// ----------------------------------------------------------------------------
interface smcc_req_if;
    import smcc_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/smcc_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smcc_rsp_if
// Response channel: valid/ready handshake carrying one result per beat.
// ----------------------------------------------------------------------------
interface smcc_rsp_if;
    import smcc_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/shunt_monitor_calibrate_convert_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shunt_monitor_calibrate_convert_unit
// Calibrates a shunt current monitor and converts raw register words into
// microvolts, millivolts, milliamperes or milliwatts.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on i_req, one beat each; each gives exactly one result
//   beat on o_rsp. Configuration (maximum current, shunt resistance, gain)
//   is to be written through i_cfg_* by the user only while the unit is idle;
//   the unit does not enforce this. It works on one request at a time with
//   a shared shift-add multiplier (one multiplier bit per cycle) and a
//   shared restoring divider (one quotient bit per cycle).
//   Work per request:
//     shunt, bus and unknown requests: result set on accept
//     current and power: one multiply, one divide
//     calibrate: four multiplies and two divides, plus one step per halving
//     of the word; fewer when a limit fails.
//   The next request can be taken in the cycle after the result is registered.
//   i_req.ready is high only while no request is in work. A finished result
//   sits in the output register; the next request is taken while it waits,
//   and the unit holds its own next result until the output is free.
//   Reset clears the calibration (step and word zero), sets the gain to the
//   widest range and leaves the output empty.
// ----------------------------------------------------------------------------
module shunt_monitor_calibrate_convert_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    smcc_req_if.sink    i_req,
    smcc_rsp_if.source  o_rsp
);
    import smcc_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_DIV  = 4'd2;
    localparam logic [3:0] S_CHK  = 4'd3;
    localparam logic [3:0] S_NOM  = 4'd4;
    localparam logic [3:0] S_CDIV = 4'd5;
    localparam logic [3:0] S_SHR  = 4'd6;
    localparam logic [3:0] S_WDIV = 4'd7;
    localparam logic [3:0] S_ACT  = 4'd8;
    localparam logic [3:0] S_CONV = 4'd9;
    localparam logic [3:0] S_SAT  = 4'd10;
    localparam logic [3:0] S_FIN  = 4'd11;

    localparam logic [5:0] MUL_LAST = 6'd24;
    localparam logic [5:0] DIV_LAST = 6'd60;

    // Configuration.
    logic [19:0] r_imax;
    logic [23:0] r_rsh;
    logic [1:0]  r_gain;

    // Calibration state.
    logic [35:0] r_step, n_step;
    logic [14:0] r_cal, n_cal;

    // Sequencer and shared datapath.
    logic [3:0]  r_state, n_state;
    logic [3:0]  r_ret, n_ret;
    logic [5:0]  r_cnt, n_cnt;
    logic [35:0] r_mc, n_mc;
    logic [24:0] r_mr, n_mr;
    logic [60:0] r_p, n_p;
    logic [48:0] r_rem, n_rem;
    logic [48:0] r_dvs, n_dvs;
    logic [14:0] r_word, n_word;
    logic        r_neg, n_neg;
    logic signed [31:0] r_res, n_res;
    logic [2:0]  r_stat, n_stat;

    // Output register.
    logic        r_ovalid;
    t_rsp        r_rsp;

    logic        w_accept;
    logic        w_out_free;
    logic [49:0] w_trial;
    logic [49:0] w_diff;
    logic        w_ge;
    logic [31:0] w_raw_sx;
    logic [15:0] w_mag;

    assign w_accept   = i_req.valid && i_req.ready;
    assign w_out_free = !r_ovalid || o_rsp.ready;

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_rsp;

    // One restoring divide step.
    assign w_trial = {r_rem, r_p[60]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    // Raw word sign-extended, and its magnitude.
    assign w_raw_sx = {{16{i_req.data.raw_word[15]}}, i_req.data.raw_word};
    assign w_mag    = i_req.data.raw_word[15] ? 16'(17'd0 - {1'b0, i_req.data.raw_word})
                                              : i_req.data.raw_word;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_imax <= '0;
            r_rsh  <= '0;
            r_gain <= 2'd3;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_IMAX:  r_imax <= i_cfg_data[19:0];
                CFG_SHUNT: r_rsh  <= i_cfg_data;
                CFG_GAIN:  r_gain <= i_cfg_data[1:0];
                default:   ;
            endcase
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_cnt   = r_cnt;
        n_mc    = r_mc;
        n_mr    = r_mr;
        n_p     = r_p;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        n_word  = r_word;
        n_neg   = r_neg;
        n_res   = r_res;
        n_stat  = r_stat;
        n_step  = r_step;
        n_cal   = r_cal;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res   = '0;
                    n_stat  = ST_OK;
                    n_state = S_FIN;
                    n_cnt   = '0;
                    n_p     = '0;
                    n_neg   = 1'b0;
                    unique case (i_req.data.req_type)
                        REQ_CAL: begin
                            if (r_imax == '0) begin
                                n_stat = ST_CUR_LOW;
                            end else if (r_rsh < SHUNT_MIN) begin
                                n_stat = ST_SHUNT_LOW;
                            end else begin
                                n_mc    = {12'd0, r_rsh};
                                n_mr    = {5'd0, r_imax};
                                n_ret   = S_CHK;
                                n_state = S_MUL;
                            end
                        end
                        REQ_SHUNT: begin
                            n_res = signed'((w_raw_sx <<< 3) + (w_raw_sx <<< 1));
                        end
                        REQ_BUS: begin
                            n_res = signed'({16'd0, i_req.data.raw_word[15:3], 3'b000} >> 1);
                        end
                        REQ_CUR: begin
                            n_neg   = i_req.data.raw_word[15];
                            n_mc    = r_step;
                            n_mr    = {9'd0, w_mag};
                            n_ret   = S_CONV;
                            n_state = S_MUL;
                        end
                        REQ_PWR: begin
                            // Twenty times the raw word needs 21 bits.
                            n_mc    = r_step;
                            n_mr    = {4'd0, 21'({i_req.data.raw_word, 4'b0000})
                                             + 21'({i_req.data.raw_word, 2'b00})};
                            n_ret   = S_CONV;
                            n_state = S_MUL;
                        end
                        default: ;
                    endcase
                end
            end
            // Shift-add multiply, multiplier MSB first.
            S_MUL: begin
                n_p  = (r_p << 1) + (r_mr[24] ? {25'd0, r_mc} : 61'd0);
                n_mr = r_mr << 1;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == MUL_LAST) begin
                    n_state = r_ret;
                end
            end
            // Restoring divide, quotient shifts into the dividend register.
            S_DIV: begin
                n_rem = w_ge ? w_diff[48:0] : w_trial[48:0];
                n_p   = {r_p[59:0], w_ge};
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == DIV_LAST) begin
                    n_state = r_ret;
                end
            end
            // Shunt voltage limit check, then nominal step product.
            S_CHK: begin
                if (r_p > {32'd0, fs_limit(r_gain)}) begin
                    n_stat  = ST_VSHUNT_HIGH;
                    n_state = S_FIN;
                end else begin
                    n_mc    = {16'd0, NANO_PER_MILLI};
                    n_mr    = {5'd0, r_imax};
                    n_p     = '0;
                    n_cnt   = '0;
                    n_ret   = S_NOM;
                    n_state = S_MUL;
                end
            end
            // Nominal step is the product over 32768.
            S_NOM: begin
                if (r_p[39:15] == '0) begin
                    n_stat  = ST_CAL_OVF;
                    n_state = S_FIN;
                end else begin
                    n_mc    = {11'd0, r_p[39:15]};
                    n_mr    = {1'b0, r_rsh};
                    n_p     = '0;
                    n_cnt   = '0;
                    n_ret   = S_CDIV;
                    n_state = S_MUL;
                end
            end
            // Word = numerator / (nominal * shunt).
            S_CDIV: begin
                n_dvs   = r_p[48:0];
                n_p     = {15'd0, CAL_NUM};
                n_rem   = '0;
                n_cnt   = '0;
                n_ret   = S_SHR;
                n_state = S_DIV;
            end
            // Halve the word until it fits in 15 bits.
            S_SHR: begin
                if (r_p[60:15] != '0) begin
                    n_p = r_p >> 1;
                end else if (r_p[14:0] == '0) begin
                    n_stat  = ST_CAL_OVF;
                    n_state = S_FIN;
                end else begin
                    n_word  = r_p[14:0];
                    n_mc    = {12'd0, r_rsh};
                    n_mr    = {10'd0, r_p[14:0]};
                    n_p     = '0;
                    n_cnt   = '0;
                    n_ret   = S_WDIV;
                    n_state = S_MUL;
                end
            end
            // Actual step = numerator / (word * shunt).
            S_WDIV: begin
                n_dvs   = r_p[48:0];
                n_p     = {15'd0, CAL_NUM};
                n_rem   = '0;
                n_cnt   = '0;
                n_ret   = S_ACT;
                n_state = S_DIV;
            end
            S_ACT: begin
                if (r_p == '0) begin
                    n_stat = ST_CAL_OVF;
                end else begin
                    n_cal  = r_word;
                    n_step = r_p[35:0];
                end
                n_state = S_FIN;
            end
            // Conversion product over one million.
            S_CONV: begin
                n_dvs   = {29'd0, NANO_PER_MILLI};
                n_rem   = '0;
                n_cnt   = '0;
                n_ret   = S_SAT;
                n_state = S_DIV;
            end
            // Apply the sign and saturate to 32 bits.
            S_SAT: begin
                if (r_neg) begin
                    if (r_p > 61'd2147483648) begin
                        n_res = 32'sh8000_0000;
                    end else begin
                        n_res = signed'(32'd0 - r_p[31:0]);
                    end
                end else begin
                    if (r_p > 61'd2147483647) begin
                        n_res = 32'sh7FFF_FFFF;
                    end else begin
                        n_res = signed'(r_p[31:0]);
                    end
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_cal    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_cal   <= n_cal;
            if (r_state == S_FIN && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_ret  <= n_ret;
        r_cnt  <= n_cnt;
        r_mc   <= n_mc;
        r_mr   <= n_mr;
        r_p    <= n_p;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
        r_word <= n_word;
        r_neg  <= n_neg;
        r_res  <= n_res;
        r_stat <= n_stat;
        if (r_state == S_FIN && w_out_free) begin
            r_rsp.scaled_value     <= r_res;
            r_rsp.status           <= r_stat;
            r_rsp.calibration_word <= r_cal;
        end
    end

`ifndef SYNTH
    // The calibration only changes when a calibrate request completes.
    a_cal_from_act: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_ACT |=> $stable(r_cal) && $stable(r_step))
        else $error("calibration state changed outside completion");

    // A new result beat only appears after the finish state.
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_FIN |=> !$rose(r_ovalid))
        else $error("result beat raised outside finish");

    // The divider never runs with a zero divisor.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_dvs != '0)
        else $error("divide by zero in serial divider");

    // A held step always comes with a nonzero calibration word.
    a_cal_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cal == '0 |-> r_step == '0)
        else $error("zero calibration word stored");
`endif

endmodule
